// File: sv/dmrw_pkg.sv
// Shared types and constants for the DNS message record walker.
`default_nettype none
package dmrw_pkg;
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NAME   = 3'd1,
        PH_LABEL  = 3'd2,
        PH_PTR    = 3'd3,
        PH_FIXED  = 3'd4,
        PH_RDATA  = 3'd5,
        PH_DONE   = 3'd6,
        PH_STOP   = 3'd7
    } t_phase;

    localparam logic [2:0] EV_QUESTION = 3'd0;
    localparam logic [2:0] EV_END_OK   = 3'd4;
    localparam logic [2:0] EV_END_STOP = 3'd5;

    localparam logic [7:0] PTR_MASK = 8'hC0;

    // one queued item: up to two results
    typedef struct packed {
        logic        rec_vld;
        logic [1:0]  rec_sect;
        logic [15:0] rec_off;
        logic [15:0] rec_size;
        logic [8:0]  rec_name;
        logic        end_vld;
        logic        end_ok;
    } t_evt;
endpackage
`default_nettype wire

// File: sv/dns_message_record_walker.sv
// Top level of the DNS message record walker.
`default_nettype none
// Walks a DNS message one byte per cycle while o_ready is high: captures the four
// section counts from the 12-byte header, then reports each question and resource
// record (section, offset, size, name size) on the byte that completes it, and an
// end beat on the last byte telling whether the walk completed or stopped. A byte
// is accepted only when the queue is not full; the classifier is combinational and
// a four-entry queue feeds the output. A byte that yields a record and the end event
// takes two beats, so rate drops only on output stalls or when such bytes cluster.
module dns_message_record_walker #(
    parameter int MAX_NAME_BYTES   = 256,
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_pkt_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_event_res,
    output logic [15:0]      o_record_offset,
    output logic [15:0]      o_record_size,
    output logic [8:0]       o_name_len,
    output logic             o_last_result
);
    dmrw_pkg::t_evt evt;
    logic evt_vld, full, acc;

    assign o_ready = !full;
    assign acc = i_valid && o_ready;

    dmrw_front #(.MAX_NAME_BYTES(MAX_NAME_BYTES), .MAX_PACKET_BYTES(MAX_PACKET_BYTES))
    u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(acc), .i_byte(i_pkt_byte),
        .i_last(i_last_byte), .o_evt(evt), .o_evt_vld(evt_vld)
    );

    dmrw_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(evt_vld), .i_evt(evt),
        .o_full(full), .o_event_res(o_event_res), .o_record_offset(o_record_offset),
        .o_record_size(o_record_size), .o_name_len(o_name_len),
        .o_last_result(o_last_result), .o_valid(o_valid), .i_ready(i_ready)
    );
endmodule
`default_nettype wire

// File: sv/dmrw_front.sv
// Byte walker: tracks header, names, fixed fields and rdata, and classifies each byte.
`default_nettype none
module dmrw_front #(
    parameter int MAX_NAME_BYTES   = 256,
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    output dmrw_pkg::t_evt        o_evt,
    output logic                  o_evt_vld
);
    localparam int NW = $clog2(MAX_NAME_BYTES + 256) + 1;

    dmrw_pkg::t_phase r_ph, n_ph;
    logic [15:0] r_off, n_off;
    logic [15:0] r_cnt [4];
    logic [15:0] n_cnt [4];
    logic [1:0]  r_sect, n_sect;
    logic [15:0] r_left, n_left;
    logic [15:0] r_start, n_start;
    logic [NW-1:0] r_name, n_name;
    logic [7:0]  r_lab, n_lab;
    logic [3:0]  r_fix, n_fix;
    logic [15:0] r_rd, n_rd;
    logic        r_stop, n_stop;

    dmrw_pkg::t_evt ev;
    logic [NW-1:0] name_add;
    logic [3:0] fix_dec;
    logic [15:0] rd_now;
    logic [15:0] left_dec;
    logic        emit;
    logic        ok;

    // pick first nonzero section at or after s
    function automatic logic [2:0] first_sect(input logic [2:0] s,
                                              input logic [63:0] c);
        logic [2:0] r;
        r = 3'd4;
        for (int k = 3; k >= 0; k--) begin
            if (3'(k) >= s && c[k*16 +: 16] != 16'd0) r = 3'(k);
        end
        return r;
    endfunction

    logic [63:0] cnt_flat;
    logic [2:0]  sel;
    logic [2:0]  sel_from;
    logic        do_sel;

    always_comb begin
        n_ph = r_ph; n_off = r_off; n_sect = r_sect; n_left = r_left;
        n_start = r_start; n_name = r_name; n_lab = r_lab; n_fix = r_fix;
        n_rd = r_rd; n_stop = r_stop;
        for (int k = 0; k < 4; k++) n_cnt[k] = r_cnt[k];
        ev = '0;
        emit = 1'b0;
        do_sel = 1'b0;
        sel_from = 3'd0;
        name_add = '0;
        fix_dec = '0;
        rd_now = r_rd;
        left_dec = '0;
        if (r_ph != dmrw_pkg::PH_STOP && 32'(r_off) >= 32'(MAX_PACKET_BYTES)) begin
            n_ph = dmrw_pkg::PH_STOP;
            n_stop = 1'b1;
        end else begin
            case (r_ph)
                dmrw_pkg::PH_HEADER: begin
                    if (r_off >= 16'd4 && r_off <= 16'd11) begin
                        if (!r_off[0])
                            n_cnt[r_off[2:1] - 2'd2] = {i_byte, 8'd0};
                        else
                            n_cnt[r_off[2:1] - 2'd2] = {r_cnt[r_off[2:1] - 2'd2][15:8], i_byte};
                    end
                    if (r_off >= 16'd11) begin
                        do_sel = 1'b1;
                        sel_from = 3'd0;
                    end
                end
                dmrw_pkg::PH_NAME: begin
                    if (r_name == '0) n_start = r_off;
                    if (i_byte == 8'd0) begin
                        n_name = r_name + 1'b1;
                        n_ph = dmrw_pkg::PH_FIXED;
                        n_fix = (r_sect == 2'd0) ? 4'd4 : 4'd10;
                    end else if ((i_byte & dmrw_pkg::PTR_MASK) == dmrw_pkg::PTR_MASK) begin
                        n_name = r_name + 1'b1;
                        n_ph = dmrw_pkg::PH_PTR;
                    end else begin
                        name_add = r_name + NW'(i_byte) + 1'b1;
                        n_name = name_add;
                        if (32'(name_add) >= 32'(MAX_NAME_BYTES)) begin
                            n_ph = dmrw_pkg::PH_STOP;
                            n_stop = 1'b1;
                        end else begin
                            n_lab = i_byte;
                            n_ph = dmrw_pkg::PH_LABEL;
                        end
                    end
                end
                dmrw_pkg::PH_LABEL: begin
                    n_lab = (r_lab != 8'd0) ? r_lab - 8'd1 : 8'd0;
                    if (n_lab == 8'd0) n_ph = dmrw_pkg::PH_NAME;
                end
                dmrw_pkg::PH_PTR: begin
                    n_name = r_name + 1'b1;
                    n_ph = dmrw_pkg::PH_FIXED;
                    n_fix = (r_sect == 2'd0) ? 4'd4 : 4'd10;
                end
                dmrw_pkg::PH_FIXED: begin
                    if (r_sect != 2'd0) begin
                        if (r_fix == 4'd2) rd_now = {i_byte, 8'd0};
                        else if (r_fix == 4'd1) rd_now = r_rd | {8'd0, i_byte};
                    end
                    n_rd = rd_now;
                    fix_dec = (r_fix != 4'd0) ? r_fix - 4'd1 : 4'd0;
                    n_fix = fix_dec;
                    if (fix_dec == 4'd0) begin
                        if (r_sect == 2'd0 || rd_now == 16'd0) emit = 1'b1;
                        else n_ph = dmrw_pkg::PH_RDATA;
                    end
                end
                dmrw_pkg::PH_RDATA: begin
                    n_rd = (r_rd != 16'd0) ? r_rd - 16'd1 : 16'd0;
                    if (n_rd == 16'd0) emit = 1'b1;
                end
                default: ;
            endcase
            if (emit) begin
                ev.rec_vld  = 1'b1;
                ev.rec_sect = r_sect;
                ev.rec_off  = r_start;
                ev.rec_size = r_off + 16'd1 - r_start;
                ev.rec_name = r_name[8:0];
                left_dec = (r_left != 16'd0) ? r_left - 16'd1 : 16'd0;
                n_left = left_dec;
                if (left_dec == 16'd0) begin
                    do_sel = 1'b1;
                    sel_from = {1'b0, r_sect} + 3'd1;
                end else begin
                    n_ph = dmrw_pkg::PH_NAME;
                    n_name = '0; n_lab = '0; n_fix = '0; n_rd = '0;
                end
            end
            if (32'(r_off) < 32'(MAX_PACKET_BYTES)) n_off = r_off + 16'd1;
        end
        for (int k = 0; k < 4; k++) cnt_flat[k*16 +: 16] = n_cnt[k];
        sel = first_sect(sel_from, cnt_flat);
        if (do_sel) begin
            if (sel == 3'd4) n_ph = dmrw_pkg::PH_DONE;
            else begin
                n_sect = sel[1:0];
                n_left = n_cnt[sel[1:0]];
                n_ph = dmrw_pkg::PH_NAME;
                n_name = '0; n_lab = '0; n_fix = '0; n_rd = '0;
            end
        end
        ok = (r_off >= 16'd12) && (n_ph == dmrw_pkg::PH_DONE) && !n_stop;
        if (i_last) begin
            ev.end_vld = 1'b1;
            ev.end_ok  = ok;
        end
    end

    assign o_evt     = ev;
    assign o_evt_vld = i_vld && (ev.rec_vld || ev.end_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_vld && i_last)) begin
            r_ph <= dmrw_pkg::PH_HEADER;
            r_off <= '0; r_sect <= '0; r_left <= '0; r_start <= '0;
            r_name <= '0; r_lab <= '0; r_fix <= '0; r_rd <= '0; r_stop <= 1'b0;
            for (int k = 0; k < 4; k++) r_cnt[k] <= '0;
        end else if (i_vld) begin
            r_ph <= n_ph; r_off <= n_off; r_sect <= n_sect; r_left <= n_left;
            r_start <= n_start; r_name <= n_name; r_lab <= n_lab; r_fix <= n_fix;
            r_rd <= n_rd; r_stop <= n_stop;
            for (int k = 0; k < 4; k++) r_cnt[k] <= n_cnt[k];
        end
    end

`ifndef SYNTHESIS
    a_off_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_off) <= 32'(MAX_PACKET_BYTES)) else $error("offset past limit");
    a_stop_ph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == dmrw_pkg::PH_STOP) |-> r_stop) else $error("stop phase without flag");
    a_rec_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && ev.rec_vld) |-> (ev.rec_name != 9'd0 || MAX_NAME_BYTES > 511))
        else $error("record with empty name");
`endif
endmodule
`default_nettype wire

// File: sv/dmrw_back.sv
// Queue of classified bytes and output serializer (record beat, then end beat).
`default_nettype none
module dmrw_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  dmrw_pkg::t_evt      i_evt,
    output logic                o_full,
    output logic [2:0]          o_event_res,
    output logic [15:0]         o_record_offset,
    output logic [15:0]         o_record_size,
    output logic [8:0]          o_name_len,
    output logic                o_last_result,
    output logic                o_valid,
    input  wire logic           i_ready
);
    localparam int DEPTH = 4;
    dmrw_pkg::t_evt r_q [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       r_rec_done, n_rec_done;
    dmrw_pkg::t_evt hd;
    logic pop, beat, show_rec;

    assign hd = r_q[r_rp];
    assign o_valid = r_cnt != 3'd0;
    assign o_full  = r_cnt == 3'(DEPTH);
    assign show_rec = hd.rec_vld && !r_rec_done;
    assign beat = o_valid && i_ready;
    assign pop  = beat && (!show_rec || !hd.end_vld);

    always_comb begin
        if (show_rec) begin
            o_event_res = {1'b0, hd.rec_sect};
            o_record_offset = hd.rec_off;
            o_record_size = hd.rec_size;
            o_name_len = hd.rec_name;
            o_last_result = !hd.end_vld;
        end else begin
            o_event_res = hd.end_ok ? dmrw_pkg::EV_END_OK : dmrw_pkg::EV_END_STOP;
            o_record_offset = '0;
            o_record_size = '0;
            o_name_len = '0;
            o_last_result = 1'b1;
        end
        n_rec_done = r_rec_done;
        if (pop) n_rec_done = 1'b0;
        else if (beat) n_rec_done = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_evt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_rec_done <= 1'b0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(pop);
            r_rec_done <= n_rec_done;
        end
    end

`ifndef SYNTHESIS
    a_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(DEPTH)) else $error("queue count out of range");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_done |-> (o_valid && hd.end_vld)) else $error("stray record-done");
`endif
endmodule
`default_nettype wire
